[hw/rtl/aou_pkg.sv]
// Shared types, constants and pipeline stage numbers for the Adam update core.
// No dependencies; only adam_optimizer_update_core imports this package.
`default_nettype none

package aou_pkg;

	localparam int ENTRIES_DEF = 4096;
	localparam int IDX_W       = 12;
	localparam int CFG_IDX_W   = 3;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_APPLY = 2'd1,
		OP_READ  = 2'd2,
		OP_STEP  = 2'd3
	} op_t;

	// Configuration register indices.
	localparam logic [CFG_IDX_W-1:0] REG_LR    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BETA1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BETA2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EPS   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WLIM  = 3'd4;

	localparam logic [31:0] LR_RST    = 32'd42949673;
	localparam logic [31:0] BETA1_RST = 32'd3865470566;
	localparam logic [31:0] BETA2_RST = 32'd4290672329;
	localparam logic [15:0] EPS_RST   = 16'd43;
	localparam logic [30:0] WLIM_RST  = 31'd1073741824;
	localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;

	// Pipeline stage numbers.
	localparam int DIV_STEPS = 32;
	localparam int ST_DIV1   = 5;
	localparam int ST_QUO    = ST_DIV1 + DIV_STEPS;
	localparam int ST_NUM    = ST_QUO + 1;
	localparam int ST_ROOT   = ST_NUM + DIV_STEPS;
	localparam int ST_DIV2   = ST_ROOT + 1;
	localparam int ST_LAST   = ST_DIV2 + DIV_STEPS;

endpackage

`default_nettype wire

[hw/rtl/aou_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module aou_ram #(
	parameter int W  = 32,
	parameter int D  = 4096,
	parameter int AW = (D > 1) ? $clog2(D) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[hw/rtl/aou_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
// Expects the initial remainder below the divisor; no package dependency.
`default_nettype none

module aou_div #(
	parameter int NW = 33,
	parameter int QW = 32
) (
	input  wire logic          clk,
	input  wire logic [NW-1:0] rem_in,
	input  wire logic [NW-1:0] den_in,
	input  wire logic [QW-1:0] low_in,
	output logic      [QW-1:0] quo_out
);

	logic [NW-1:0] rem_q [QW];
	logic [NW-1:0] den_q [QW];
	logic [QW-1:0] low_q [QW];
	logic [QW-1:0] quo_q [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [NW-1:0] rem_p;
		logic [NW-1:0] den_p;
		logic [QW-1:0] low_p;
		logic [QW-1:0] quo_p;
		logic [NW:0]   trial;
		logic [NW:0]   diff;

		if (k == 0) begin : g_first
			assign rem_p = rem_in;
			assign den_p = den_in;
			assign low_p = low_in;
			assign quo_p = '0;
		end else begin : g_next
			assign rem_p = rem_q[k-1];
			assign den_p = den_q[k-1];
			assign low_p = low_q[k-1];
			assign quo_p = quo_q[k-1];
		end

		always_comb begin
			trial = {rem_p, low_p[QW-1]};
			diff  = trial - {1'b0, den_p};
		end

		always_ff @(posedge clk) begin
			if (trial >= {1'b0, den_p}) begin
				rem_q[k] <= diff[NW-1:0];
				quo_q[k] <= {quo_p[QW-2:0], 1'b1};
			end else begin
				rem_q[k] <= trial[NW-1:0];
				quo_q[k] <= {quo_p[QW-2:0], 1'b0};
			end
			den_q[k] <= den_p;
			low_q[k] <= {low_p[QW-2:0], 1'b0};
		end
	end

	assign quo_out = quo_q[QW-1];

endmodule

`default_nettype wire

[hw/rtl/aou_sqrt.sv]
// Pipelined integer square root, rounding down, one root bit per stage.
// No package dependency.
`default_nettype none

module aou_sqrt #(
	parameter int XW = 64
) (
	input  wire logic              clk,
	input  wire logic [XW-1:0]     x_in,
	output logic      [XW/2-1:0]   root_out
);

	localparam int QW = XW / 2;
	localparam int RW = QW + 4;

	logic [RW-1:0] rem_q  [QW];
	logic [XW-1:0] x_q    [QW];
	logic [QW-1:0] root_q [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [RW-1:0] rem_p;
		logic [XW-1:0] x_p;
		logic [QW-1:0] root_p;
		logic [RW-1:0] r4;
		logic [RW-1:0] trial;

		if (k == 0) begin : g_first
			assign rem_p  = '0;
			assign x_p    = x_in;
			assign root_p = '0;
		end else begin : g_next
			assign rem_p  = rem_q[k-1];
			assign x_p    = x_q[k-1];
			assign root_p = root_q[k-1];
		end

		// Bring down the next pair of radicand bits and try 4r+1.
		always_comb begin
			r4    = {rem_p[RW-3:0], x_p[XW-1:XW-2]};
			trial = {2'b00, root_p, 2'b01};
		end

		always_ff @(posedge clk) begin
			if (r4 >= trial) begin
				rem_q[k]  <= r4 - trial;
				root_q[k] <= {root_p[QW-2:0], 1'b1};
			end else begin
				rem_q[k]  <= r4;
				root_q[k] <= {root_p[QW-2:0], 1'b0};
			end
			x_q[k] <= {x_p[XW-3:0], 2'b00};
		end
	end

	assign root_out = root_q[QW-1];

endmodule

`default_nettype wire

[hw/rtl/adam_optimizer_update_core.sv]
// Adam update core: one request may enter every cycle while busy is low; its result
// strobes on done in order, and the receiver cannot stall it. busy rises only while
// a load or apply to the same index is still in flight, because the stores are read
// on entry and written back from the final stage. Depth comes from the front stages,
// two 32-step dividers in series and the 32-step square root. Reset clears the pipeline valids,
// sets both beta powers to one and the registers to defaults; the stores are undefined.
`default_nettype none

module adam_optimizer_update_core #(
	parameter int ENTRIES = aou_pkg::ENTRIES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [1:0]                    operation,
	input  wire logic [aou_pkg::IDX_W-1:0]     index,
	input  wire logic signed [31:0]            value,
	output logic                               done,
	output logic signed [31:0]                 weight,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [aou_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]                   cfg_data
);

	import aou_pkg::*;

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] idx;
		logic             inr;
		logic             wr;
		logic [31:0]      w;
		logic [31:0]      m_new;
		logic [31:0]      v_new;
		logic [32:0]      c1;
		logic [32:0]      c2;
		logic [62:0]      num;
		logic             sat_m;
		logic             sat_v;
		logic             sat_s;
	} side_t;

	// Configuration and step state
	logic [31:0] lr_q, beta1_q, beta2_q;
	logic [15:0] eps_q;
	logic [30:0] wlim_q;
	logic [32:0] pow1_q, pow2_q;

	logic        acc;
	logic        hit;
	logic        in_range;
	logic [63:0] pprod1, pprod2;

	side_t side_s [1:ST_LAST];
	logic  vld_s  [1:ST_LAST];

	assign cfg_ready = 1'b1;
	assign acc       = start & ~busy;
	assign in_range  = 32'(index) < 32'(ENTRIES);
	assign pprod1    = 64'(pow1_q[31:0]) * 64'(beta1_q);
	assign pprod2    = 64'(pow2_q[31:0]) * 64'(beta2_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q    <= LR_RST;
			beta1_q <= BETA1_RST;
			beta2_q <= BETA2_RST;
			eps_q   <= EPS_RST;
			wlim_q  <= WLIM_RST;
			pow1_q  <= ONE_Q32;
			pow2_q  <= ONE_Q32;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_LR:    lr_q    <= cfg_data;
					REG_BETA1: beta1_q <= cfg_data;
					REG_BETA2: beta2_q <= cfg_data;
					REG_EPS:   eps_q   <= cfg_data[15:0];
					REG_WLIM:  wlim_q  <= cfg_data[30:0];
					default: ;
				endcase
			end
			// A power never exceeds one, so its top bit means exactly one.
			if (acc && op_t'(operation) == OP_STEP) begin
				pow1_q <= pow1_q[32] ? {1'b0, beta1_q} : {1'b0, pprod1[63:32]};
				pow2_q <= pow2_q[32] ? {1'b0, beta2_q} : {1'b0, pprod2[63:32]};
			end
		end
	end

	// Bias corrections taken at entry, a zero correction replaced by one LSB
	logic [32:0] c1_raw, c2_raw;
	assign c1_raw = ONE_Q32 - pow1_q;
	assign c2_raw = ONE_Q32 - pow2_q;

	// Stores
	logic        wr_en_q;
	logic [IDX_W-1:0] wr_idx_q;
	logic [31:0] wr_w_q, wr_m_q, wr_v_q;
	logic [31:0] w_rd, m_rd, v_rd;

	aou_ram #(.W(32), .D(ENTRIES), .AW(AW)) u_ram_w (
		.clk(clk), .we(wr_en_q), .waddr(AW'(wr_idx_q)), .wdata(wr_w_q),
		.raddr(AW'(index)), .rdata(w_rd)
	);
	aou_ram #(.W(32), .D(ENTRIES), .AW(AW)) u_ram_m (
		.clk(clk), .we(wr_en_q), .waddr(AW'(wr_idx_q)), .wdata(wr_m_q),
		.raddr(AW'(index)), .rdata(m_rd)
	);
	aou_ram #(.W(32), .D(ENTRIES), .AW(AW)) u_ram_v (
		.clk(clk), .we(wr_en_q), .waddr(AW'(wr_idx_q)), .wdata(wr_v_q),
		.raddr(AW'(index)), .rdata(v_rd)
	);

	// Hold off a request whose element is still being updated further down.
	always_comb begin
		hit = 1'b0;
		for (int s = 1; s <= ST_LAST; s++) begin
			if (vld_s[s] && side_s[s].wr && side_s[s].idx == index) begin
				hit = 1'b1;
			end
		end
		if (wr_en_q && wr_idx_q == index) begin
			hit = 1'b1;
		end
		busy = hit;
	end

	// Gradient clamp to plus or minus one, then Q4.27 to Q1.30
	logic signed [31:0] gclamp;
	always_comb begin
		if (value > 32'sd134217728) begin
			gclamp = 32'sd134217728;
		end else if (value < -32'sd134217728) begin
			gclamp = -32'sd134217728;
		end else begin
			gclamp = value;
		end
	end

	// Front stages
	logic signed [31:0] g_s1;
	logic [61:0] gsq_s2;
	logic [31:0] dm_mag_s2, m_s2, v_s2;
	logic        dm_neg_s2;
	logic [63:0] prod_m_s2;
	logic [31:0] dv_mag_s3, v_s3;
	logic        dv_neg_s3;
	logic [31:0] dv_mag_s4, v_s4;
	logic        dv_neg_s4;
	logic [63:0] prod_v_s4;
	logic [31:0] mabs_s5;

	logic [32:0] k1, k2;
	logic [31:0] gneg, gabs;
	logic signed [32:0] dm_c, dm_n;
	logic [31:0] dm_mag;
	logic [31:0] t_m, m_new;
	logic [31:0] g2;
	logic signed [32:0] dv_c, dv_n;
	logic [31:0] dv_mag;
	logic [31:0] t_v, v_new;
	logic [31:0] mneg_val, mabs;

	always_comb begin
		k1     = ONE_Q32 - {1'b0, beta1_q};
		k2     = ONE_Q32 - {1'b0, beta2_q};
		gneg   = -g_s1;
		gabs   = g_s1[31] ? gneg : g_s1;
		dm_c   = {g_s1[31], g_s1} - {m_rd[31], m_rd};
		dm_n   = -dm_c;
		dm_mag = dm_c[32] ? dm_n[31:0] : dm_c[31:0];
		t_m    = k1[32] ? dm_mag_s2 : prod_m_s2[63:32];
		m_new  = dm_neg_s2 ? (m_s2 - t_m) : (m_s2 + t_m);
		g2     = (gsq_s2[61:60] != 2'b00) ? 32'hFFFF_FFFF : gsq_s2[59:28];
		dv_c   = {1'b0, g2} - {1'b0, v_s2};
		dv_n   = -dv_c;
		dv_mag = dv_c[32] ? dv_n[31:0] : dv_c[31:0];
		t_v    = k2[32] ? dv_mag_s4 : prod_v_s4[63:32];
		v_new  = dv_neg_s4 ? (v_s4 - t_v) : (v_s4 + t_v);
		mneg_val = -side_s[4].m_new;
		mabs   = side_s[4].m_new[31] ? mneg_val : side_s[4].m_new;
	end

	always_ff @(posedge clk) begin
		g_s1      <= {gclamp[28:0], 3'b000};
		gsq_s2    <= 62'(gabs) * 62'(gabs);
		dm_mag_s2 <= dm_mag;
		dm_neg_s2 <= dm_c[32];
		prod_m_s2 <= 64'(dm_mag) * 64'(k1[31:0]);
		m_s2      <= m_rd;
		v_s2      <= v_rd;
		dv_mag_s3 <= dv_mag;
		dv_neg_s3 <= dv_c[32];
		v_s3      <= v_s2;
		dv_mag_s4 <= dv_mag_s3;
		dv_neg_s4 <= dv_neg_s3;
		v_s4      <= v_s3;
		prod_v_s4 <= 64'(dv_mag_s3) * 64'(k2[31:0]);
		mabs_s5   <= mabs;
	end

	// Dividers for the bias-corrected moments
	logic [31:0] qm, qv;

	aou_div #(.NW(33), .QW(DIV_STEPS)) u_div_m (
		.clk(clk), .rem_in({1'b0, mabs_s5}), .den_in(side_s[ST_DIV1].c1),
		.low_in('0), .quo_out(qm)
	);
	aou_div #(.NW(33), .QW(DIV_STEPS)) u_div_v (
		.clk(clk), .rem_in({1'b0, side_s[ST_DIV1].v_new}), .den_in(side_s[ST_DIV1].c2),
		.low_in('0), .quo_out(qv)
	);

	logic [30:0] mhat;
	logic [31:0] vhat_s38;
	assign mhat = side_s[ST_QUO].sat_m ? 31'h7FFF_FFFF : qm[30:0];

	always_ff @(posedge clk) begin
		vhat_s38 <= side_s[ST_QUO].sat_v ? 32'hFFFF_FFFF : qv;
	end

	logic [31:0] root;
	aou_sqrt #(.XW(64)) u_sqrt (
		.clk(clk), .x_in({vhat_s38, 32'd0}), .root_out(root)
	);

	logic [32:0] den, den_fix;
	logic [35:0] dd, d2_s71;
	always_comb begin
		den     = {1'b0, root} + {17'd0, eps_q};
		den_fix = (den == 33'd0) ? 33'd1 : den;
		dd      = {den_fix, 3'b000};
	end

	always_ff @(posedge clk) begin
		d2_s71 <= dd;
	end

	logic [31:0] qs;
	aou_div #(.NW(36), .QW(DIV_STEPS)) u_div_s (
		.clk(clk), .rem_in(36'(side_s[ST_DIV2].num[62:32])), .den_in(d2_s71),
		.low_in(side_s[ST_DIV2].num[31:0]), .quo_out(qs)
	);

	// Side band travelling with each request; a few fields are filled in on the way.
	side_t side_nx [1:ST_LAST];

	always_comb begin
		for (int s = 2; s <= ST_LAST; s++) begin
			side_nx[s] = side_s[s-1];
		end
		side_nx[1].op    = op_t'(operation);
		side_nx[1].idx   = index;
		side_nx[1].inr   = in_range;
		side_nx[1].wr    = in_range && (op_t'(operation) == OP_LOAD ||
			op_t'(operation) == OP_APPLY);
		side_nx[1].w     = value;
		side_nx[1].m_new = '0;
		side_nx[1].v_new = '0;
		side_nx[1].c1    = (c1_raw == 33'd0) ? 33'd1 : c1_raw;
		side_nx[1].c2    = (c2_raw == 33'd0) ? 33'd1 : c2_raw;
		side_nx[1].num   = '0;
		side_nx[1].sat_m = 1'b0;
		side_nx[1].sat_v = 1'b0;
		side_nx[1].sat_s = 1'b0;

		side_nx[2].w = (side_s[1].op == OP_LOAD) ? side_s[1].w : w_rd;
		side_nx[3].m_new = m_new;
		side_nx[ST_DIV1].v_new = v_new;
		side_nx[ST_DIV1].sat_m = {1'b0, mabs, 1'b0} >= {1'b0, side_s[4].c1};
		side_nx[ST_DIV1].sat_v = {1'b0, v_new} >= side_s[4].c2;
		side_nx[ST_NUM].num = 63'(lr_q) * 63'(mhat);
		side_nx[ST_DIV2].sat_s = 36'(side_s[ST_ROOT].num[62:32]) >= dd;
	end

	always_ff @(posedge clk) begin
		for (int s = 1; s <= ST_LAST; s++) begin
			side_s[s] <= side_nx[s];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 1; s <= ST_LAST; s++) begin
				vld_s[s] <= 1'b0;
			end
		end else begin
			vld_s[1] <= acc;
			for (int s = 2; s <= ST_LAST; s++) begin
				vld_s[s] <= vld_s[s-1];
			end
		end
	end

	// Final stage: apply the step, clamp, select the result
	side_t              fin;
	logic [32:0]        step;
	logic signed [34:0] wt, lim;
	logic [31:0]        wclamp, res;

	always_comb begin
		fin  = side_s[ST_LAST];
		step = fin.sat_s ? ONE_Q32 : {1'b0, qs};
		lim  = {4'd0, wlim_q};
		if (fin.m_new[31]) begin
			wt = {{3{fin.w[31]}}, fin.w} + {2'b00, step};
		end else begin
			wt = {{3{fin.w[31]}}, fin.w} - {2'b00, step};
		end
		if (wt > lim) begin
			wclamp = lim[31:0];
		end else if (wt < -lim) begin
			wclamp = 32'(-lim);
		end else begin
			wclamp = wt[31:0];
		end
		if (!fin.inr) begin
			res = '0;
		end else begin
			unique case (fin.op)
				OP_APPLY: res = wclamp;
				OP_LOAD:  res = fin.w;
				OP_READ:  res = fin.w;
				OP_STEP:  res = '0;
				default:  res = '0;
			endcase
		end
	end

	logic done_q;
	logic [31:0] weight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= 1'b0;
			wr_en_q <= 1'b0;
		end else begin
			done_q  <= vld_s[ST_LAST];
			wr_en_q <= vld_s[ST_LAST] && fin.wr;
		end
	end

	always_ff @(posedge clk) begin
		weight_q <= res;
		wr_idx_q <= fin.idx;
		if (fin.op == OP_APPLY) begin
			wr_w_q <= wclamp;
			wr_m_q <= fin.m_new;
			wr_v_q <= fin.v_new;
		end else begin
			wr_w_q <= fin.w;
			wr_m_q <= '0;
			wr_v_q <= '0;
		end
	end

	assign done   = done_q;
	assign weight = weight_q;

endmodule

`default_nettype wire
